### rtl/cfr_pkg.sv
package cfr_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TOUCH  = 2'd2,
    REQ_EVICT  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_BINARY  = 2'd0,
    KIND_FILE    = 2'd1,
    KIND_ANON    = 2'd2,
    KIND_INVALID = 2'd3
  } page_kind_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_VICTIM    = 2'd1,
    STAT_NO_VICTIM = 2'd2,
    STAT_BAD_KIND  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_SWAP_OUT  = 2'd1,
    ACT_WRITEBACK = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TOUCH,
    ST_SWEEP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] frame_index;
    logic       is_mapped;
    logic [1:0] page_kind;
    logic       set_accessed;
    logic       set_dirty;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] victim_frame;
    logic [1:0] action;
    logic [1:0] victim_new_kind;
  } rsp_t;

  // One frame table entry as it is kept in the memory.
  typedef struct packed {
    logic       valid;
    logic       mapped;
    logic       use_bit;
    logic       dirty;
    logic [1:0] kind;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

endpackage

### rtl/cfr_req_if.sv
interface cfr_req_if;
  import cfr_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/cfr_rsp_if.sv
interface cfr_rsp_if;
  import cfr_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/cfr_ram.sv
module cfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/clock_frame_replacement_core.sv
// Frame table with second-chance (clock) replacement. Each request item on
// req_i is an add, remove, touch or evict, and each gives exactly one result
// item on rsp_o. The table lives in one synchronous memory of FRAMES entries
// with a registered read. Add and remove are single writes. Touch is a
// read-modify-write. Evict walks the clock hand one entry per cycle and
// examines at most 2 * FRAMES entries; when no valid, mapped frame exists
// the sweep gives up after two full turns with a no-victim status and the
// hand is left where it started. After reset the block clears the memory,
// one entry a cycle, before it takes the first item. A finished result sits
// in an output register, so the block returns to idle and takes the next
// item while the previous result still waits; it stalls only when a second
// result is ready before the first has been taken.
module clock_frame_replacement_core #(
  parameter int unsigned FRAMES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cfr_req_if.sink         req_i,
  cfr_rsp_if.source       rsp_o
);
  import cfr_pkg::*;

  localparam int unsigned AW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(2 * FRAMES);
  localparam logic [AW-1:0] LastSlot = AW'(FRAMES - 1);
  localparam logic [CW-1:0] SweepLast = CW'(2 * FRAMES - 1);

  // Advance a slot index around the ring.
  function automatic logic [AW-1:0] next_slot(logic [AW-1:0] a);
    logic [AW-1:0] n;
    n = (a == LastSlot) ? '0 : a + 1'b1;
    return n;
  endfunction

  state_e        state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] hand_q, hand_d;
  logic          tok_q, tok_d;
  logic          tacc_q, tacc_d;
  logic          tdirty_q, tdirty_d;
  rsp_t          res_q, res_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_data_q, out_data_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EntryWidth-1:0] ram_rdata;
  entry_t        entry;

  req_t          req;
  logic          in_ok;
  logic [AW-1:0] in_addr;
  logic          out_free;
  logic          fin;
  rsp_t          fin_res;
  logic          in_ready;
  logic          cand;

  cfr_ram #(
    .Width (EntryWidth),
    .Depth (FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign entry    = entry_t'(ram_rdata);
  assign req      = req_i.data;
  assign in_ok    = 32'(req.frame_index) < FRAMES;
  assign in_addr  = AW'(req.frame_index);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign cand     = entry.valid && entry.mapped;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    hand_d      = hand_q;
    tok_d       = tok_q;
    tacc_d      = tacc_q;
    tdirty_d    = tdirty_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = slot_q;
    ram_wdata   = '0;
    ram_raddr   = ptr_q;
    fin         = 1'b0;
    fin_res     = '0;
    in_ready    = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep zeros through the whole table once after reset.
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        if (ptr_q == LastSlot) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (req_i.valid) begin
          unique case (req.req_type)
            REQ_ADD: begin
              ram_we           = in_ok;
              ram_waddr        = in_addr;
              ram_wdata.valid  = 1'b1;
              ram_wdata.mapped = req.is_mapped;
              ram_wdata.kind   = req.page_kind;
              fin              = 1'b1;
            end
            REQ_REMOVE: begin
              ram_we    = in_ok;
              ram_waddr = in_addr;
              fin       = 1'b1;
            end
            REQ_TOUCH: begin
              ram_raddr = in_addr;
              slot_d    = in_addr;
              tok_d     = in_ok;
              tacc_d    = req.set_accessed;
              tdirty_d  = req.set_dirty;
              state_d   = ST_TOUCH;
            end
            REQ_EVICT: begin
              ram_raddr = hand_q;
              slot_d    = hand_q;
              ptr_d     = next_slot(hand_q);
              cnt_d     = '0;
              state_d   = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_TOUCH: begin
        // Touching a free slot changes nothing.
        if (tok_q && entry.valid) begin
          ram_we            = 1'b1;
          ram_wdata         = entry;
          ram_wdata.use_bit = entry.use_bit | tacc_q;
          ram_wdata.dirty   = entry.dirty | tdirty_q;
        end
        fin = 1'b1;
      end
      ST_SWEEP: begin
        if (cand && !entry.use_bit) begin
          // Victim found; the hand moves past it.
          hand_d               = next_slot(slot_q);
          fin                  = 1'b1;
          fin_res.victim_frame = 6'(slot_q);
          fin_res.status       = STAT_VICTIM;
          unique case (entry.kind)
            KIND_BINARY: begin
              if (entry.dirty) begin
                fin_res.action          = ACT_SWAP_OUT;
                fin_res.victim_new_kind = KIND_ANON;
              end else begin
                fin_res.action          = ACT_NONE;
                fin_res.victim_new_kind = KIND_BINARY;
              end
            end
            KIND_FILE: begin
              fin_res.action          = entry.dirty ? ACT_WRITEBACK : ACT_NONE;
              fin_res.victim_new_kind = KIND_FILE;
            end
            KIND_ANON: begin
              fin_res.action          = ACT_SWAP_OUT;
              fin_res.victim_new_kind = KIND_ANON;
            end
            KIND_INVALID: begin
              fin_res.status          = STAT_BAD_KIND;
              fin_res.action          = ACT_NONE;
              fin_res.victim_new_kind = KIND_INVALID;
            end
            default: ;
          endcase
          // A known kind frees the slot; an unknown kind keeps it as is.
          ram_we = (entry.kind != KIND_INVALID);
        end else begin
          if (cand) begin
            // Second chance: clear the accessed bit and move on.
            ram_we            = 1'b1;
            ram_wdata         = entry;
            ram_wdata.use_bit = 1'b0;
          end
          if (cnt_q == SweepLast) begin
            fin            = 1'b1;
            fin_res.status = STAT_NO_VICTIM;
          end else begin
            ram_raddr = ptr_q;
            slot_d    = ptr_q;
            ptr_d     = next_slot(ptr_q);
            cnt_d     = cnt_q + 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished item goes straight to the output register when it is free,
    // and otherwise waits in the result register.
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_data_d  = fin_res;
        state_d     = ST_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = ST_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      cnt_q       <= '0;
      hand_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      hand_q      <= hand_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    tok_q      <= tok_d;
    tacc_q     <= tacc_d;
    tdirty_q   <= tdirty_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  // The write-back of one slot never meets the read of the next one.
  a_sweep_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && ram_we && !fin) |-> (ram_waddr != ram_raddr))
    else $error("sweep write and read hit the same slot");

  // The sweep stops after two turns of the ring.
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (cnt_q <= SweepLast))
    else $error("sweep ran past two turns");

  // A chosen victim of known kind is freed in the same cycle.
  a_victim_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && fin_res.status == STAT_VICTIM) |-> (ram_we && ram_wdata == '0))
    else $error("victim slot not freed");

  // No item is taken while the table is being cleared.
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req_i.ready)
    else $error("item accepted during clearing pass");

  // A no-victim sweep leaves the hand where it started.
  a_hand_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && fin_res.status == STAT_NO_VICTIM) |=> (hand_q == $past(hand_q)))
    else $error("hand moved on a sweep with no victim");

endmodule
